// File: hw/rtl/double_tag_vlan_translation_table_defines.svh
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef DOUBLE_TAG_VLAN_TRANSLATION_TABLE_DEFINES_SVH
`define DOUBLE_TAG_VLAN_TRANSLATION_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTVT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTVT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dtvt_pkg.sv
package dtvt_pkg;

  localparam int MAX_OUT_PORTS = 4;
  localparam int VID_BITS      = 6;

  localparam int VID_W     = 12;
  localparam int KEY_BITS  = 2 * VID_BITS;
  localparam int DEPTH     = 1 << KEY_BITS;
  localparam int ENTRY_W   = VID_W + 1;
  localparam int NPORT_W   = $clog2(MAX_OUT_PORTS + 1);
  localparam int STATUS_W  = 3;
  localparam int FOUND_W   = 2;

  localparam logic [VID_W-1:0] ID_LIMIT = 12'd4094;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DEL    = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_IN  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_OUT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd4;

  localparam logic CFG_OWN_PORT  = 1'b0;
  localparam logic CFG_NUM_PORTS = 1'b1;

  typedef struct packed {
    logic [1:0]       op;
    logic [3:0]       in_port;
    logic [3:0]       out_port;
    logic [VID_W-1:0] vlan_outer;
    logic [VID_W-1:0] vlan_inner;
    logic [VID_W-1:0] vlan_new;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_port;
    logic [VID_W-1:0]    vlan_result;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } ctrl_sts_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

// File: hw/rtl/dtvt_ctrl.sv
module dtvt_ctrl
  import dtvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.clear   = 1'b0;
    cmd.capture = 1'b0;
    cmd.load    = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: cmd.load = sts.out_free;
      default: cmd.clear = 1'b0;
    endcase
  end

endmodule

// File: hw/rtl/dtvt_datapath.sv
module dtvt_datapath
  import dtvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  input  in_item_t  in_data,
  output out_item_t out_data,
  output logic      out_valid,
  input  logic      out_ready,
  input  logic      cfg_valid,
  input  logic      cfg_index,
  input  logic [3:0] cfg_data
);

  logic [3:0]              own_port_id;
  logic [2:0]              num_out_ports;
  logic [NPORT_W-1:0]      nports;
  in_item_t                item;
  logic [KEY_BITS-1:0]     clr_addr;
  logic [KEY_BITS-1:0]     rd_addr;
  logic [KEY_BITS-1:0]     key;
  logic [KEY_BITS-1:0]     wr_addr;
  logic [ENTRY_W-1:0]      wr_data;
  logic [ENTRY_W-1:0]      rd_data [MAX_OUT_PORTS];
  logic                    is_mod;
  logic                    key_in_span;
  logic                    ids_ok;
  logic                    wr_ok;
  out_item_t               result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_port_id   <= '0;
      num_out_ports <= 3'd4;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_OWN_PORT) begin
        own_port_id <= cfg_data;
      end else begin
        num_out_ports <= cfg_data[2:0];
      end
    end
  end

  assign nports = (32'(num_out_ports) > MAX_OUT_PORTS) ? NPORT_W'(MAX_OUT_PORTS)
                                                       : NPORT_W'(num_out_ports);

  // Clearing sweep, one row of all banks per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clr_last = (clr_addr == '1);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_data;
  end

  assign rd_addr = {in_data.vlan_outer[VID_BITS-1:0], in_data.vlan_inner[VID_BITS-1:0]};
  assign key     = {item.vlan_outer[VID_BITS-1:0], item.vlan_inner[VID_BITS-1:0]};

  assign is_mod      = (item.op == OP_ADD) || (item.op == OP_DEL);
  assign key_in_span = ((item.vlan_outer >> VID_BITS) == '0) &&
                       ((item.vlan_inner >> VID_BITS) == '0);
  assign ids_ok      = (item.vlan_outer <= ID_LIMIT) && (item.vlan_inner <= ID_LIMIT) &&
                       (item.vlan_new <= ID_LIMIT) && key_in_span;
  assign wr_ok       = is_mod && (item.in_port == own_port_id) &&
                       (32'(item.out_port) < 32'(nports)) && ids_ok;

  assign wr_addr = cmd.clear ? clr_addr : key;
  assign wr_data = (cmd.clear || item.op == OP_DEL) ? '0 : {1'b1, item.vlan_new};

  for (genvar b = 0; b < MAX_OUT_PORTS; b++) begin : g_bank
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic               we;

    assign we = cmd.clear || (cmd.load && wr_ok && (32'(item.out_port) == b));

    always_ff @(posedge clk) begin
      if (we) mem[wr_addr] <= wr_data;
      if (cmd.capture) rd_data[b] <= mem[rd_addr];
    end
  end

  always_comb begin
    result = '0;
    if (is_mod) begin
      if (item.in_port != own_port_id) begin
        result.status = ST_BAD_IN;
      end else if (32'(item.out_port) >= 32'(nports)) begin
        result.status = ST_BAD_OUT;
      end else if (!ids_ok) begin
        result.status = ST_RANGE;
      end
    end else if (item.op == OP_LOOKUP) begin
      result.status = ST_MISS;
      if (key_in_span) begin
        // Scan downward so the lowest valid port wins
        for (int p = MAX_OUT_PORTS - 1; p >= 0; p--) begin
          if (rd_data[p][ENTRY_W-1] && (p < 32'(nports))) begin
            result.status      = ST_OK;
            result.found_port  = FOUND_W'(p);
            result.vlan_result = rd_data[p][VID_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) out_data <= result;
  end

endmodule

// File: hw/rtl/double_tag_vlan_translation_table.sv
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------
// in      | in_valid / in_ready  | in_data (in_item_t)
// out     | out_valid / out_ready| out_data (out_item_t)
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request is accepted in S_IDLE, where one entry is read from every port
// bank; in S_EXEC the block then picks the lowest valid port, writes back an add
// or delete and loads the result register.
// After reset a clearing pass zeroes the banks, one row per cycle, over all DEPTH
// (4096) rows with in_ready low; configuration writes are taken throughout.
// A result not yet taken holds the block in S_EXEC until the output
// register frees.
`include "double_tag_vlan_translation_table_defines.svh"

module double_tag_vlan_translation_table
  import dtvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  dtvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtvt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  `DTVT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken in flight")
  `DTVT_ASSERT_NEXT(a_load_shows, cmd.load, out_valid, "loaded result not presented")
  `DTVT_ASSERT_NOW(a_no_overwrite, cmd.load, !out_valid || out_ready, "pending result overwritten")
  `DTVT_ASSERT_NOW(a_clear_quiet, cmd.clear, !in_ready && !cmd.load, "traffic during clearing")

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import dtvt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int KEY_SPAN = 1 << VID_BITS;
  localparam int PHASE_ITEMS = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [3:0] PHASE_PORTS [6] = '{4'd1, 4'd4, 4'd2, 4'd3, 4'd7, 4'd4};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_OWN_PORT;
  logic [3:0] cfg_data = 4'd0;

  double_tag_vlan_translation_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the route banks and registers
  logic [ENTRY_W-1:0] route_tbl [MAX_OUT_PORTS][DEPTH];
  logic [3:0] cfg_own = 4'd0;
  logic [2:0] cfg_nports = 3'd4;

  out_item_t awaited_answers[$];
  out_item_t want;
  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  function automatic out_item_t resolve_route(in_item_t req);
    out_item_t ans;
    int unsigned ports;
    logic key_ok;
    logic hit;
    logic [KEY_BITS-1:0] key;
    ans = '0;
    hit = 1'b0;
    ports = (cfg_nports > MAX_OUT_PORTS) ? MAX_OUT_PORTS : cfg_nports;
    key_ok = (req.vlan_outer < KEY_SPAN) && (req.vlan_inner < KEY_SPAN);
    key = {req.vlan_outer[VID_BITS-1:0], req.vlan_inner[VID_BITS-1:0]};
    case (req.op)
      OP_ADD, OP_DEL: begin
        if (req.in_port != cfg_own) begin
          ans.status = ST_BAD_IN;
        end else if (req.out_port >= ports) begin
          ans.status = ST_BAD_OUT;
        end else if (req.vlan_outer > ID_LIMIT || req.vlan_inner > ID_LIMIT ||
                     req.vlan_new > ID_LIMIT || !key_ok) begin
          ans.status = ST_RANGE;
        end else if (req.op == OP_ADD) begin
          route_tbl[req.out_port][key] = {1'b1, req.vlan_new};
        end else begin
          route_tbl[req.out_port][key] = '0;
        end
      end
      OP_LOOKUP: begin
        ans.status = ST_MISS;
        if (key_ok) begin
          // lowest port with a valid entry wins
          for (int p = 0; p < ports; p++) begin
            if (!hit && route_tbl[p][key][VID_W]) begin
              hit = 1'b1;
              ans.status = ST_OK;
              ans.found_port = FOUND_W'(p);
              ans.vlan_result = route_tbl[p][key][VID_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic in_item_t make_request(logic [1:0] op, logic [3:0] src, logic [3:0] dst,
                                            logic [11:0] outer, logic [11:0] inner,
                                            logic [11:0] vnew);
    in_item_t req;
    req.op = op;
    req.in_port = src;
    req.out_port = dst;
    req.vlan_outer = outer;
    req.vlan_inner = inner;
    req.vlan_new = vnew;
    return req;
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    int unsigned roll;
    int unsigned ports;
    ports = (cfg_nports > MAX_OUT_PORTS) ? MAX_OUT_PORTS : cfg_nports;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      // noise: any field value at all
      req.op = 2'($urandom_range(0, 3));
      req.in_port = 4'($urandom_range(0, 15));
      req.out_port = 4'($urandom_range(0, 15));
      req.vlan_outer = 12'($urandom_range(0, 4095));
      req.vlan_inner = 12'($urandom_range(0, 4095));
      req.vlan_new = 12'($urandom_range(0, 4095));
    end else begin
      roll = $urandom_range(0, 99);
      req.op = (roll < 40) ? OP_ADD : (roll < 55) ? OP_DEL : OP_LOOKUP;
      req.in_port = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15)) : cfg_own;
      if (ports == 0 || $urandom_range(0, 19) == 0)
        req.out_port = 4'($urandom_range(0, 15));
      else
        req.out_port = 4'($urandom_range(0, ports - 1));
      // crowd keys into a small corner so lookups hit often
      req.vlan_outer = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, KEY_SPAN - 1))
                                                     : 12'($urandom_range(0, 7));
      req.vlan_inner = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, KEY_SPAN - 1))
                                                     : 12'($urandom_range(0, 7));
      req.vlan_new = ($urandom_range(0, 24) == 0) ? 12'hFFF : 12'($urandom_range(0, 4094));
    end
    return req;
  endfunction

  task automatic send_request(input in_item_t req);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    awaited_answers.push_back(resolve_route(req));
    burst_left--;
  endtask

  // Hold input until every outstanding answer has come back
  task automatic drain_results();
    if (awaited_answers.size() != 0) begin
      in_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clk);
    end
  endtask

  task automatic set_config(input logic [3:0] own, input logic [3:0] nports);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_OWN_PORT;
    cfg_data <= own;
    do @(posedge clk); while (!cfg_ready);
    cfg_own = own;
    cfg_index <= CFG_NUM_PORTS;
    cfg_data <= nports;
    do @(posedge clk); while (!cfg_ready);
    cfg_nports = nports[2:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_table();
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd0, 12'd0, 12'd0));
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd63, 12'd63, 12'd0));
    send_request(make_request(OP_ADD, 4'd0, 4'd1, 12'd5, 12'd6, 12'd7));
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd5, 12'd6, 12'd0));
  endtask

  task automatic test_directed_ops();
    set_config(4'd5, 4'd4);
    send_request(make_request(OP_ADD, 4'd5, 4'd2, 12'd0, 12'd0, 12'd0));
    send_request(make_request(OP_ADD, 4'd5, 4'd3, 12'd63, 12'd63, 12'd4094));
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd0, 12'd0, 12'd0));
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd63, 12'd63, 12'd0));
    // a lower port shadows a higher one until deleted
    send_request(make_request(OP_ADD, 4'd5, 4'd0, 12'd63, 12'd63, 12'd17));
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd63, 12'd63, 12'd0));
    send_request(make_request(OP_DEL, 4'd5, 4'd0, 12'd63, 12'd63, 12'd0));
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd63, 12'd63, 12'd0));
    // input port is checked before output port, output port before ranges
    send_request(make_request(OP_ADD, 4'd4, 4'd15, 12'hFFF, 12'hFFF, 12'hFFF));
    send_request(make_request(OP_DEL, 4'd10, 4'd2, 12'd1, 12'd1, 12'd1));
    send_request(make_request(OP_ADD, 4'd5, 4'd4, 12'hFFF, 12'd0, 12'd0));
    send_request(make_request(OP_ADD, 4'd5, 4'd15, 12'd0, 12'd0, 12'd0));
    send_request(make_request(OP_ADD, 4'd5, 4'd1, 12'd64, 12'd0, 12'd1));
    send_request(make_request(OP_ADD, 4'd5, 4'd1, 12'd0, 12'hFFF, 12'd1));
    send_request(make_request(OP_ADD, 4'd5, 4'd1, 12'd0, 12'd0, 12'hFFF));
    send_request(make_request(OP_ADD, 4'd5, 4'd1, 12'd4094, 12'd0, 12'd1));
    send_request(make_request(OP_DEL, 4'd5, 4'd1, 12'd0, 12'd0, 12'hFFF));
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd64, 12'd0, 12'd0));
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd0, 12'hFFF, 12'd0));
    send_request(make_request(OP_DEL, 4'd5, 4'd1, 12'd10, 12'd10, 12'd0));
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd10, 12'd10, 12'd0));
    send_request(make_request(OP_UNUSED, 4'hF, 4'hF, 12'hFFF, 12'hFFF, 12'hFFF));
  endtask

  task automatic test_port_count();
    set_config(4'd5, 4'd0);
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd0, 12'd0, 12'd0));
    send_request(make_request(OP_ADD, 4'd5, 4'd0, 12'd1, 12'd1, 12'd1));
    set_config(4'd5, 4'd7);
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd63, 12'd63, 12'd0));
    send_request(make_request(OP_ADD, 4'd5, 4'd4, 12'd1, 12'd1, 12'd1));
    set_config(4'd5, 4'hA);
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd0, 12'd0, 12'd0));
    set_config(4'd5, 4'd1);
    send_request(make_request(OP_ADD, 4'd5, 4'd0, 12'd1, 12'd2, 12'd99));
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd1, 12'd2, 12'd0));
    send_request(make_request(OP_LOOKUP, 4'd0, 4'd0, 12'd63, 12'd63, 12'd0));
  endtask

  task automatic test_random_traffic();
    logic [3:0] own;
    for (int phase = 0; phase < 6; phase++) begin
      own = (phase == 0) ? 4'd0 : (phase == 1) ? 4'd15 : 4'($urandom_range(0, 15));
      set_config(own, PHASE_PORTS[phase]);
      repeat (PHASE_ITEMS) send_request(random_request());
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_len = 400;
    hold_seq++;
    repeat (30) send_request(random_request());
    drain_results();
  endtask

  // Output side: stall pattern plus a single long hold-off in the backpressure test
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_answers.size() == 0) begin
        $error("result transfer with nothing outstanding: status %0d port %0d vlan %0d",
               out_data.status, out_data.found_port, out_data.vlan_result);
        fail_count++;
      end else begin
        want = awaited_answers.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.found_port !== want.found_port) begin
          $error("found_port: expected %0d, got %0d", want.found_port, out_data.found_port);
          fail_count++;
        end
        if (out_data.vlan_result !== want.vlan_result) begin
          $error("vlan_result: expected %0d, got %0d", want.vlan_result, out_data.vlan_result);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < MAX_OUT_PORTS; p++)
      for (int k = 0; k < DEPTH; k++)
        route_tbl[p][k] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_directed_ops();
    test_port_count();
    test_random_traffic();
    test_backpressure();
    drain_results();
    // catch any stray result after the last expected one
    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/dtvt_pkg.sv
hw/rtl/dtvt_ctrl.sv
hw/rtl/dtvt_datapath.sv
hw/rtl/double_tag_vlan_translation_table.sv
verif/tb.sv
